FILE: rtl/core/wsrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsrs_pkg: shared types and constants of the weighted score rank sorter
// Holds the entry record, the per-cell control bundle, the controller states
// and the fixed field widths.
// ----------------------------------------------------------------------------
package wsrs_pkg;

	localparam int unsigned ID_W    = 24;
	localparam int unsigned SCORE_W = 7;
	localparam int unsigned RANK_W  = 6;
	localparam int unsigned SUM_W   = 10;
	localparam int unsigned PROD_W  = 18;

	// floor(x / 5) == (x * 205) >> 10 for every sum below 1024
	localparam int unsigned TOTAL_RECIP = 205;
	localparam int unsigned TOTAL_SHIFT = 10;

	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 64;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] dis;
		logic [SCORE_W-1:0] rep;
		logic [SCORE_W-1:0] tst;
		logic [SCORE_W-1:0] total;
	} entry_t;

	typedef struct packed {
		logic ins;    // place the new entry into the chain
		logic shift;  // rotate the chain one place toward cell 0
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_READ
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/core/wsrs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsrs_cell: one place of the sorted insertion chain
// Compares its stored total with the new entry, keeps, takes the new entry or
// takes its left neighbor on insert, and takes its right neighbor on rotate.
// ----------------------------------------------------------------------------
module wsrs_cell (
	input  wire                  clk,
	input  wsrs_pkg::cell_ctrl_t ctrl,
	input  wire                  occupied,
	input  wsrs_pkg::entry_t     new_entry,
	input  wsrs_pkg::entry_t     left_entry,
	input  wire                  left_ge,
	input  wsrs_pkg::entry_t     right_entry,
	output wsrs_pkg::entry_t     entry,
	output logic                 ge
);
	import wsrs_pkg::*;

	entry_t entry_q;

	// stored entry stays ahead of the newcomer when its total is equal or higher
	assign ge    = occupied && (entry_q.total >= new_entry.total);
	assign entry = entry_q;

	// entry register
	always_ff @(posedge clk) begin
		if (ctrl.ins && !ge) begin
			entry_q <= left_ge ? new_entry : left_entry;
		end else if (ctrl.shift) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/weighted_score_rank_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// Insert: accepted when idle; the total is registered, then the chain updates in ST_INS; no result.
// Readout: after the transfer, ST_READ loads the first result into the output register, then one result
// per cycle while m_tready is high; the cell chain rotates one place per result.
// The next item is accepted in the cycle after the last result is loaded.
// Reset clears the entry count, drop flag, controller and output valid; cell contents are
// not reset and are read only below the entry count.
// ----------------------------------------------------------------------------
// weighted_score_rank_sorter: stable descending insertion sorter with ranks
// Keeps up to CAPACITY records in a chain of cells ordered by weighted total
// and streams them out with competition rank on a readout request.
// ----------------------------------------------------------------------------
module weighted_score_rank_sorter #(
	parameter int unsigned CAPACITY = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// record_id[23:0], discussion_score[30:24], report_score[37:31], test_score[44:38]
	input  wire [wsrs_pkg::IN_DATA_W-1:0]     s_tdata,
	// kind[0]
	input  wire                               s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// valid_res[0], rank[6:1], entry_id[30:7], entry_discussion[37:31],
	// entry_report[44:38], entry_test[51:45], entry_total[58:52], overflowed[59]
	output logic [wsrs_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);
	import wsrs_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	state_t          state_q, state_d;
	cell_ctrl_t      ctrl;
	logic [CW-1:0]   count_q;
	logic            drop_q;
	logic [CW-1:0]   k_q;
	logic [RANK_W-1:0]  rank_q;
	logic [SCORE_W-1:0] prev_total_q;
	entry_t          new_s1;

	logic            s_fire;
	logic            load_out;
	logic            last_item;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;
	logic [RANK_W-1:0] cur_rank;

	entry_t cell_entry [CAPACITY];
	logic   cell_ge    [CAPACITY];

	logic               out_valid_q;
	logic               out_vres_q;
	logic [RANK_W-1:0]  out_rank_q;
	entry_t             out_entry_q;
	logic               out_ovf_q;
	logic               out_last_q;

	assign s_fire = s_tvalid && s_tready;

	// weighted total: (2d + 2r + 6t) / 10 == (d + r + 3t) / 5
	assign sum  = {3'b000, s_tdata[30:24]} + {3'b000, s_tdata[37:31]}
	            + {3'b000, s_tdata[44:38]} + {2'b00, s_tdata[44:38], 1'b0};
	assign prod = PROD_W'(sum) * PROD_W'(TOTAL_RECIP);

	// new entry register
	always_ff @(posedge clk) begin
		if (s_fire) begin
			new_s1.id    <= s_tdata[23:0];
			new_s1.dis   <= s_tdata[30:24];
			new_s1.rep   <= s_tdata[37:31];
			new_s1.tst   <= s_tdata[44:38];
			new_s1.total <= prod[TOTAL_SHIFT +: SCORE_W];
		end
	end

	// readout step control
	assign load_out  = (state_q == ST_READ) && (!out_valid_q || m_tready);
	assign last_item = (count_q == '0) || (k_q == count_q - CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					state_d = s_tuser ? ST_READ : ST_INS;
				end
			end
			ST_INS: begin
				state_d = ST_IDLE;
			end
			ST_READ: begin
				if (load_out && last_item) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// controller outputs
	always_comb begin
		s_tready   = 1'b0;
		ctrl.ins   = 1'b0;
		ctrl.shift = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_INS: begin
				ctrl.ins = 1'b1;
			end
			ST_READ: begin
				ctrl.shift = load_out && (count_q != '0);
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// controller state, fill count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.ins) begin
				if (count_q == CAP_CNT) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// chain of cells, rotate wraps at the last occupied place
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		logic   left_g;
		entry_t right_e;

		if (i == 0) begin : g_head
			assign left_e = new_s1;
			assign left_g = 1'b1;
		end else begin : g_body
			assign left_e = cell_entry[i-1];
			assign left_g = cell_ge[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = cell_entry[0];
		end else begin : g_mid
			assign right_e = (count_q == CW'(i + 1)) ? cell_entry[0] : cell_entry[i+1];
		end

		wsrs_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (count_q > CW'(i)),
			.new_entry   (new_s1),
			.left_entry  (left_e),
			.left_ge     (left_g),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	// competition rank of the entry at the head of the chain
	always_comb begin
		if (k_q == '0) begin
			cur_rank = RANK_W'(1);
		end else if (cell_entry[0].total != prev_total_q) begin
			cur_rank = RANK_W'(k_q + CW'(1));
		end else begin
			cur_rank = rank_q;
		end
	end

	// readout position and rank tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (s_fire) begin
			k_q <= '0;
		end else if (load_out) begin
			k_q <= k_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rank_q       <= cur_rank;
			prev_total_q <= cell_entry[0].total;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ovf_q  <= drop_q;
			out_last_q <= last_item;
			if (count_q == '0) begin
				out_vres_q  <= 1'b0;
				out_rank_q  <= '0;
				out_entry_q <= '0;
			end else begin
				out_vres_q  <= 1'b1;
				out_rank_q  <= cur_rank;
				out_entry_q <= cell_entry[0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0000, out_ovf_q, out_entry_q.total, out_entry_q.tst,
	                   out_entry_q.rep, out_entry_q.dis, out_entry_q.id,
	                   out_rank_q, out_vres_q};

	// fill count never passes the chain length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	// head of the chain is in descending order when idle
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q >= CW'(2)) |->
		(cell_entry[0].total >= cell_entry[1].total))
		else $error("chain head out of order");

	// drop flag is sticky
	a_drop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |=> drop_q)
		else $error("drop flag cleared");

	// readout position stays inside the occupied part
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && count_q != '0) |-> (k_q < count_q))
		else $error("readout position beyond entry count");

	// an insert grows the table unless it was already full
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS && count_q != CAP_CNT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the table");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the weighted score rank sorter
// Feeds insert and readout requests with random gaps, keeps its own sorted
// copy of the record table and compares every streamed row, field by field,
// with the row that copy predicts. One long receiver hold backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
	import wsrs_pkg::*;

	localparam int unsigned CAPACITY    = 32;
	localparam int unsigned N_RANDOM    = 360;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned HOLD_AT     = 60;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned TAIL_CYCLES = 20;

	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	// output tdata layout, lowest field first
	localparam int unsigned OFS_RANK  = 1;
	localparam int unsigned OFS_ID    = OFS_RANK + RANK_W;
	localparam int unsigned OFS_DIS   = OFS_ID + ID_W;
	localparam int unsigned OFS_REP   = OFS_DIS + SCORE_W;
	localparam int unsigned OFS_TST   = OFS_REP + SCORE_W;
	localparam int unsigned OFS_TOTAL = OFS_TST + SCORE_W;
	localparam int unsigned OFS_OVF   = OFS_TOTAL + SCORE_W;

	typedef struct {
		logic               kind;
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] dis;
		logic [SCORE_W-1:0] rep;
		logic [SCORE_W-1:0] tst;
	} request_t;

	typedef struct {
		logic              valid_res;
		logic [RANK_W-1:0] rank;
		entry_t            entry;
		logic              overflowed;
		logic              last;
	} ranked_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	wire                   s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = KIND_INSERT;
	wire                   m_tvalid;
	logic                  m_tready = 1'b0;
	wire  [OUT_DATA_W-1:0] m_tdata;
	wire                   m_tlast;

	request_t    request_q[$];
	ranked_row_t expected_rows[$];

	// predicted table contents
	entry_t      sorted_rows[CAPACITY];
	int          sorted_len = 0;
	logic        dropped    = 1'b0;

	logic        in_xfer      = 1'b0;
	int unsigned n_requests   = 0;
	int unsigned n_sent       = 0;
	int unsigned n_accepted   = 0;
	int unsigned n_results    = 0;
	int unsigned n_errors     = 0;
	int unsigned idle_cycles  = 0;
	int unsigned send_gap     = 0;
	int unsigned sink_stall   = 0;
	int unsigned hold_left    = 0;
	logic        hold_done    = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	weighted_score_rank_sorter #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// scores in range, above range, at the edges, or clustered to force ties
	function automatic logic [SCORE_W-1:0] pick_score();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return SCORE_W'($urandom_range(0, 100));
		if (roll < 72)
			return SCORE_W'($urandom_range(101, 127));
		if (roll < 82) begin
			case ($urandom_range(0, 2))
				0: return '0;
				1: return SCORE_W'(100);
				default: return '1;
			endcase
		end
		return SCORE_W'($urandom_range(45, 55));
	endfunction

	task automatic add_insert(input logic [ID_W-1:0] id, input logic [SCORE_W-1:0] dis,
			input logic [SCORE_W-1:0] rep, input logic [SCORE_W-1:0] tst);
		request_t req;
		req.kind = KIND_INSERT;
		req.id   = id;
		req.dis  = dis;
		req.rep  = rep;
		req.tst  = tst;
		request_q.push_back(req);
	endtask

	task automatic add_readout();
		request_t req;
		req.kind = KIND_READOUT;
		req.id   = ID_W'($urandom);
		req.dis  = SCORE_W'($urandom);
		req.rep  = SCORE_W'($urandom);
		req.tst  = SCORE_W'($urandom);
		request_q.push_back(req);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			n_errors++;
		end
	endtask

	// stable descending insert and ranked readout of the predicted table
	always @(posedge clk) begin : table_predict
		entry_t            fresh;
		ranked_row_t       row;
		int unsigned       weighted_sum;
		int                slot;
		int                fill;
		logic [RANK_W-1:0] run_rank;
		in_xfer <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			n_accepted++;
			if (s_tuser == KIND_INSERT) begin
				fresh.id     = s_tdata[0 +: ID_W];
				fresh.dis    = s_tdata[ID_W +: SCORE_W];
				fresh.rep    = s_tdata[ID_W + SCORE_W +: SCORE_W];
				fresh.tst    = s_tdata[ID_W + 2 * SCORE_W +: SCORE_W];
				weighted_sum = 2 * fresh.dis + 2 * fresh.rep + 6 * fresh.tst;
				fresh.total  = SCORE_W'(weighted_sum / 10);
				slot = 0;
				while (slot < sorted_len && sorted_rows[slot].total >= fresh.total)
					slot++;
				// full table: the row landing in last place falls off
				if (sorted_len == CAPACITY) begin
					dropped = 1'b1;
					fill    = CAPACITY - 1;
				end else begin
					fill = sorted_len;
				end
				if (slot < CAPACITY) begin
					for (int i = fill; i > slot; i--)
						sorted_rows[i] = sorted_rows[i - 1];
					sorted_rows[slot] = fresh;
					sorted_len        = fill + 1;
				end
			end else if (sorted_len == 0) begin
				row.valid_res  = 1'b0;
				row.rank       = '0;
				row.entry      = '0;
				row.overflowed = dropped;
				row.last       = 1'b1;
				expected_rows.push_back(row);
			end else begin
				run_rank = RANK_W'(1);
				for (int k = 0; k < sorted_len; k++) begin
					if (k > 0 && sorted_rows[k].total != sorted_rows[k - 1].total)
						run_rank = RANK_W'(k + 1);
					row.valid_res  = 1'b1;
					row.rank       = run_rank;
					row.entry      = sorted_rows[k];
					row.overflowed = dropped;
					row.last       = (k + 1 == sorted_len);
					expected_rows.push_back(row);
				end
			end
		end
	end

	// compare each output transfer with the oldest predicted row
	always @(posedge clk) begin : row_check
		ranked_row_t want;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (expected_rows.size() == 0) begin
				$display("%0t: unexpected row, expected none, actual tdata=%h tlast=%b",
					$time, m_tdata, m_tlast);
				n_errors++;
			end else begin
				want = expected_rows.pop_front();
				check_field("valid_res", 32'(want.valid_res), 32'(m_tdata[0]));
				check_field("rank", 32'(want.rank), 32'(m_tdata[OFS_RANK +: RANK_W]));
				check_field("entry_id", 32'(want.entry.id), 32'(m_tdata[OFS_ID +: ID_W]));
				check_field("entry_discussion", 32'(want.entry.dis),
					32'(m_tdata[OFS_DIS +: SCORE_W]));
				check_field("entry_report", 32'(want.entry.rep),
					32'(m_tdata[OFS_REP +: SCORE_W]));
				check_field("entry_test", 32'(want.entry.tst),
					32'(m_tdata[OFS_TST +: SCORE_W]));
				check_field("entry_total", 32'(want.entry.total),
					32'(m_tdata[OFS_TOTAL +: SCORE_W]));
				check_field("overflowed", 32'(want.overflowed), 32'(m_tdata[OFS_OVF]));
				check_field("last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	// request driver, holds each item until its transfer
	always @(negedge clk) begin : request_drive
		request_t pending;
		if (arst_n && (!s_tvalid || in_xfer)) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (request_q.size() > 0) begin
				pending  = request_q.pop_front();
				n_sent++;
				s_tvalid <= 1'b1;
				s_tuser  <= pending.kind;
				s_tdata  <= IN_DATA_W'({pending.tst, pending.rep, pending.dis, pending.id});
				send_gap <= ((n_sent % 120) < 30) ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready, with random stalls and one long hold
	always @(negedge clk) begin : row_sink
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_results >= HOLD_AT) begin
			m_tready  <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (sink_stall > 0) begin
			m_tready   <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else begin
			m_tready   <= 1'b1;
			sink_stall <= ((n_results % 200) < 50) ? 0 : pick_gap();
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : stall_watch
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("weighted_score_rank_sorter verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned batch;
		// directed: empty readout, field extremes, ties, floor edges
		add_readout();
		add_insert(24'h000000, 7'd0, 7'd0, 7'd0);
		add_insert(24'hFFFFFF, 7'd127, 7'd127, 7'd127);
		add_insert(24'h000001, 7'd100, 7'd100, 7'd100);
		add_insert(24'h000002, 7'd100, 7'd100, 7'd100);
		add_insert(24'h000003, 7'd50, 7'd50, 7'd100);
		add_insert(24'h000004, 7'd100, 7'd0, 7'd100);
		add_insert(24'h000005, 7'd0, 7'd0, 7'd1);
		add_insert(24'h000006, 7'd1, 7'd1, 7'd1);
		add_insert(24'hAAAAAA, 7'd85, 7'd42, 7'd21);
		add_insert(24'h555555, 7'd42, 7'd85, 7'd106);
		add_readout();
		add_readout();

		// random: runs of inserts closed by a readout, some bare readouts
		while (request_q.size() < 13 + N_RANDOM) begin
			if ($urandom_range(0, 99) < 85)
				batch = $urandom_range(1, 12);
			else
				batch = $urandom_range(20, 45);
			if ($urandom_range(0, 99) < 8)
				batch = 0;
			repeat (batch)
				add_insert(ID_W'($urandom), pick_score(), pick_score(), pick_score());
			add_readout();
			if ($urandom_range(0, 99) < 10)
				add_readout();
		end
		n_requests = request_q.size();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_requests)
			@(posedge clk);
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (n_errors == 0 && expected_rows.size() == 0)
			$display("weighted_score_rank_sorter verification clean");
		else
			$display("weighted_score_rank_sorter verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/wsrs_pkg.sv
rtl/core/wsrs_cell.sv
rtl/core/weighted_score_rank_sorter.sv
verif/tb_top.sv
